>>> sv/afrp_pkg.sv
// shared types and constants for the api frame receive parser
package afrp_pkg;

    // field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned TIMEOUT_W = 16;

    // protocol constants
    localparam logic [BYTE_W-1:0]    START_DELIM     = 8'h7E;
    localparam logic [BYTE_W-1:0]    SUM_GOOD        = 8'hFF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_DEFAULT = 16'd1000;

    // input mode codes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // result kind codes
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd3;

    // parser phase codes
    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_HUNT   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN_HI = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd3;

    // one input request
    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    // input stage as seen by the parser
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

endpackage

>>> sv/afrp_if.sv
// valid/ready channel interfaces for input requests and result requests
interface afrp_in_if;
    import afrp_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface afrp_out_if;
    import afrp_pkg::*;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic [INDEX_W-1:0] byte_index;

    modport source (output valid, output kind, output payload_byte, output byte_index,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input byte_index,
                    output ready);
endinterface

>>> sv/afrp_in_reg.sv
// input register stage holding one request for the parser
module afrp_in_reg
    import afrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    afrp_in_if.sink     i_in,
    input  logic        i_take,
    output t_stage      o_stage
);

    logic  r_valid;
    t_item r_item;

    // accept when empty or when the held request leaves this cycle
    assign i_in.ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.mode    <= i_in.mode;
            r_item.rx_byte <= i_in.rx_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

>>> sv/afrp_parse.sv
// frame parser state and result register
module afrp_parse
    import afrp_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_stage               i_stage,
    input  logic [TIMEOUT_W-1:0] i_timeout_ticks,
    output logic                 o_take,
    afrp_out_if.source           o_out
);

    localparam int unsigned CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [PHASE_W-1:0]    r_phase,   n_phase;
    logic [BYTE_W-1:0]     r_len_hi,  n_len_hi;
    logic [INDEX_W-1:0]    r_frame_len, n_frame_len;
    logic [INDEX_W-1:0]    r_taken,   n_taken;
    logic [BYTE_W-1:0]     r_sum,     n_sum;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;

    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_kind,    n_kind;
    logic [BYTE_W-1:0]     r_pbyte,   n_pbyte;
    logic [INDEX_W-1:0]    r_index,   n_index;

    logic                  yields;
    logic                  advance;
    logic                  fire;
    logic [TIMER_BITS-1:0] tick_count;
    logic [BYTE_W-1:0]     sum_add;

    // saturating tick count and timeout test
    assign tick_count = (r_elapsed == TIMER_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign fire = (CMP_W'(tick_count) >= CMP_W'(i_timeout_ticks)) || (tick_count == TIMER_MAX);
    assign sum_add = r_sum + i_stage.item.rx_byte;

    // does the held request produce a result
    always_comb begin
        if (i_stage.item.mode == MODE_TICK) begin
            yields = (r_phase != PH_HUNT) && fire;
        end else begin
            yields = (r_phase == PH_DATA);
        end
    end

    // move on when the result slot can take the result, if any
    assign advance = i_stage.valid && (!yields || !r_out_valid || o_out.ready);
    assign o_take  = advance;

    // next state and result
    always_comb begin
        n_phase     = r_phase;
        n_len_hi    = r_len_hi;
        n_frame_len = r_frame_len;
        n_taken     = r_taken;
        n_sum       = r_sum;
        n_elapsed   = r_elapsed;
        n_kind      = KIND_PAYLOAD;
        n_pbyte     = '0;
        n_index     = r_taken;
        if (i_stage.item.mode == MODE_TICK) begin
            if (r_phase != PH_HUNT) begin
                n_elapsed = tick_count;
                if (fire) begin
                    n_kind  = KIND_TIMEOUT;
                    n_phase = PH_HUNT;
                end
            end
        end else begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    n_len_hi = i_stage.item.rx_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_frame_len = {r_len_hi, i_stage.item.rx_byte};
                    n_phase     = ({r_len_hi, i_stage.item.rx_byte} == '0) ? PH_HUNT : PH_DATA;
                end
                PH_DATA: begin
                    n_sum = sum_add;
                    if (r_taken < r_frame_len) begin
                        n_kind  = KIND_PAYLOAD;
                        n_pbyte = i_stage.item.rx_byte;
                        n_index = r_taken;
                        n_taken = r_taken + 1'b1;
                    end else begin
                        n_kind  = (sum_add == SUM_GOOD) ? KIND_GOOD : KIND_BAD;
                        n_index = r_frame_len;
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (i_stage.item.rx_byte == START_DELIM) begin
                        n_phase   = PH_LEN_HI;
                        n_taken   = '0;
                        n_sum     = '0;
                        n_elapsed = '0;
                    end
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_len_hi    <= '0;
            r_frame_len <= '0;
            r_taken     <= '0;
            r_sum       <= '0;
            r_elapsed   <= '0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_len_hi    <= n_len_hi;
            r_frame_len <= n_frame_len;
            r_taken     <= n_taken;
            r_sum       <= n_sum;
            r_elapsed   <= n_elapsed;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && yields) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (advance && yields) begin
            r_kind  <= n_kind;
            r_pbyte <= n_pbyte;
            r_index <= n_index;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.payload_byte = r_pbyte;
    assign o_out.byte_index   = r_index;

    // a produced result always shows up next cycle
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && yields |=> r_out_valid)
        else $error("result request lost");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(advance && yields))
        else $error("stalled result overwritten");

    // any frame end sends the parser back to hunting
    a_end_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && yields && (n_kind != KIND_PAYLOAD) |=> r_phase == PH_HUNT)
        else $error("frame end did not return to hunting");

endmodule

>>> sv/api_frame_receive_parser_core.sv
// top level of the api frame receive parser
// Usage:
//   i_in carries input requests: mode 0 is a received serial byte in rx_byte,
//   mode 1 is one time tick. o_out carries result requests: kind 0 is a
//   payload byte with its index, kind 1 a good frame, kind 2 a bad checksum,
//   kind 3 a timeout; byte_index then holds the frame length or the count of
//   payload bytes taken. i_cfg_we with i_cfg_wdata sets the timeout in ticks,
//   counted from the start delimiter; write it only while the block is idle.
// Results: an accepted request waits in the input register, and the parse
//   logic loads its result into the result register when it advances.
// Throughput: one request per cycle while no result is stalled; the single
//   pass through the phase logic and the 8-bit checksum add sets that figure.
// Reset: i_rst_n low for one clock clears both stages, puts the parser in
//   delimiter hunt and loads the timeout with 1000.
// Stall: while o_out.ready is low a held result waits; requests that make
//   no result keep flowing, and one that makes a result waits in the input
//   register, so i_in.ready drops only when that register is also full.
module api_frame_receive_parser_core
    import afrp_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    afrp_in_if.sink              i_in,
    afrp_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [TIMEOUT_W-1:0] i_cfg_wdata
);

    logic [TIMEOUT_W-1:0] r_timeout;
    t_stage               stage;
    logic                 take;

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_DEFAULT;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // input register stage
    afrp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_stage (stage)
    );

    // parser and result register
    afrp_parse #(
        .TIMER_BITS (TIMER_BITS)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stage         (stage),
        .i_timeout_ticks (r_timeout),
        .o_take          (take),
        .o_out           (o_out)
    );

endmodule

>>> test/tb_top.sv
// testbench for the api frame receive parser: request driver, parser prediction, result checks
`timescale 1ns / 100ps

module tb_top;
    import afrp_pkg::*;

    localparam int unsigned HALF_PERIOD   = 10;
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned RANDOM_ITEMS  = 1750;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned WATCHDOG_NS   = 60_000_000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    // one expected or observed result request
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [INDEX_W-1:0] byte_index;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [TIMEOUT_W-1:0] i_cfg_wdata;

    afrp_in_if  in_ch ();
    afrp_out_if out_ch ();

    api_frame_receive_parser_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // free running clock
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // byte/tick stream waiting to be driven, and parser events still due
    t_item   rx_stream[$];
    t_result parser_events_due[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned mismatches     = 0;
    int unsigned kind_seen[4]   = '{0, 0, 0, 0};

    // parser shadow state
    logic [PHASE_W-1:0]   parse_phase;
    logic [BYTE_W-1:0]    len_high;
    logic [INDEX_W-1:0]   frame_len;
    logic [INDEX_W-1:0]   bytes_taken;
    logic [BYTE_W-1:0]    payload_sum;
    logic [15:0]          tick_count;
    logic [TIMEOUT_W-1:0] timeout_ticks;

    task automatic reset_parser_model();
        parse_phase   = PH_HUNT;
        len_high      = '0;
        frame_len     = '0;
        bytes_taken   = '0;
        payload_sum   = '0;
        tick_count    = '0;
        timeout_ticks = TIMEOUT_DEFAULT;
    endtask

    // advance the shadow parser by one request, return 1 when it yields a result
    function automatic bit parse_request(input t_item req, output t_result res);
        res = '0;
        if (req.mode == MODE_TICK) begin
            if (parse_phase == PH_HUNT) return 1'b0;
            if (tick_count != TICKS_MAX) tick_count = tick_count + 16'd1;
            if (tick_count >= timeout_ticks || tick_count == TICKS_MAX) begin
                res.kind       = KIND_TIMEOUT;
                res.byte_index = bytes_taken;
                parse_phase    = PH_HUNT;
                return 1'b1;
            end
            return 1'b0;
        end
        case (parse_phase)
            PH_LEN_HI: begin
                len_high    = req.rx_byte;
                parse_phase = PH_LEN_LO;
                return 1'b0;
            end
            PH_LEN_LO: begin
                frame_len   = {len_high, req.rx_byte};
                parse_phase = (frame_len == '0) ? PH_HUNT : PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                payload_sum = payload_sum + req.rx_byte;
                if (bytes_taken < frame_len) begin
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = req.rx_byte;
                    res.byte_index   = bytes_taken;
                    bytes_taken      = bytes_taken + 16'd1;
                    return 1'b1;
                end
                res.kind       = (payload_sum == SUM_GOOD) ? KIND_GOOD : KIND_BAD;
                res.byte_index = frame_len;
                parse_phase    = PH_HUNT;
                return 1'b1;
            end
            default: begin
                parse_phase = PH_HUNT;
                if (req.rx_byte == START_DELIM) begin
                    parse_phase = PH_LEN_HI;
                    bytes_taken = '0;
                    payload_sum = '0;
                    tick_count  = '0;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // request driver: predict on acceptance, then present the next request or idle
    always @(posedge i_clk) begin : req_driver
        t_result res;
        t_item   req;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                accepted_count++;
                req = '{mode: in_ch.mode, rx_byte: in_ch.rx_byte};
                if (parse_request(req, res)) parser_events_due.push_back(res);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req = rx_stream.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.mode    <= req.mode;
                    in_ch.rx_byte <= req.rx_byte;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each accepted result with the oldest due event
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{kind: out_ch.kind, payload_byte: out_ch.payload_byte,
                        byte_index: out_ch.byte_index};
                if (parser_events_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: kind %0d byte %02h index %0d",
                                 got.kind, got.payload_byte, got.byte_index);
                end else begin
                    want = parser_events_due.pop_front();
                    checked_count++;
                    kind_seen[want.kind]++;
                    if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                        got.byte_index !== want.byte_index) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected kind %0d byte %02h index %0d, %s %0d %02h %0d",
                                     want.kind, want.payload_byte, want.byte_index,
                                     "got", got.kind, got.payload_byte, got.byte_index);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // stream building helpers
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        rx_stream.push_back('{mode: MODE_BYTE, rx_byte: b});
        queued_count++;
    endtask

    task automatic push_tick();
        logic [BYTE_W-1:0] junk;
        junk = 8'($urandom_range(0, 255));
        rx_stream.push_back('{mode: MODE_TICK, rx_byte: junk});
        queued_count++;
    endtask

    task automatic maybe_tick(input int unsigned tick_pct);
        if ($urandom_range(0, 99) < tick_pct) push_tick();
    endtask

    // whole frame with random payload, checksum good or corrupted, stray ticks inside
    task automatic push_frame(input int unsigned len, input bit good, input int unsigned tick_pct);
        logic [15:0]       len16;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        len16 = 16'(len);
        sum   = '0;
        push_byte(START_DELIM);
        maybe_tick(tick_pct);
        push_byte(len16[15:8]);
        maybe_tick(tick_pct);
        push_byte(len16[7:0]);
        for (int i = 0; i < len; i++) begin
            maybe_tick(tick_pct);
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            push_byte(b);
        end
        b = SUM_GOOD - sum;
        if (!good) b = b + 8'($urandom_range(1, 255));
        maybe_tick(tick_pct);
        push_byte(b);
    endtask

    // mostly well formed frames, the rest stray bytes, idle ticks, zero length frames and cut or bad frames
    task automatic add_random_traffic(input int unsigned n);
        int unsigned       start;
        int unsigned       len;
        int unsigned       pick;
        int unsigned       cut;
        logic [15:0]       len16;
        logic [BYTE_W-1:0] b;
        start = queued_count;
        while (queued_count - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 300)
                                                   : $urandom_range(1, 8);
                push_frame(len, $urandom_range(0, 3) != 0, (timeout_ticks < 64) ? 3 : 10);
            end else if (pick < 80) begin
                // stray byte while hunting, never a delimiter
                b = 8'($urandom_range(0, 254));
                if (b >= START_DELIM) b = b + 8'd1;
                push_byte(b);
            end else if (pick < 85) begin
                push_tick();
            end else if (pick < 90) begin
                push_byte(START_DELIM);
                push_byte(8'h00);
                push_byte(8'h00);
            end else if (timeout_ticks <= 64) begin
                // cut frame with any length, left for the timeout to abandon
                len16 = 16'($urandom_range(0, 65535));
                push_byte(START_DELIM);
                push_byte(len16[15:8]);
                push_byte(len16[7:0]);
                cut = $urandom_range(0, 4);
                repeat (cut) push_byte(8'($urandom_range(0, 255)));
                repeat (int'(timeout_ticks) + 1) push_tick();
            end else begin
                push_frame($urandom_range(1, 6), 1'b0, 0);
            end
        end
    endtask

    // wait until every request is in and every due event has come out
    task automatic wait_drained();
        do @(posedge i_clk);
        while (rx_stream.size() != 0 || in_ch.valid || parser_events_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= v;
        timeout_ticks = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_pressure(input int unsigned idle_mode);
        case (idle_mode)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 64; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 64; end
            default: begin send_idle_pct <= 17; recv_stall_pct <= 17; end
        endcase
    endtask

    // stimulus sequence
    initial begin : stimulus
        logic [TIMEOUT_W-1:0] phase_timeout[RANDOM_PHASES];
        phase_timeout = '{16'd1000, 16'd1, 16'd4, 16'd65535, 16'd12, 16'd0, 16'd30, 16'd1000};

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_BYTE;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        reset_parser_model();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at the reset timeout: hunting tick and noise, zero length, good and bad frames
        push_tick();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(START_DELIM); push_byte(8'h00); push_byte(8'h00);
        push_byte(START_DELIM); push_byte(8'h00); push_byte(8'h02);
        push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00);
        push_byte(START_DELIM); push_byte(8'h00); push_byte(8'h01);
        push_byte(START_DELIM); push_byte(8'h12);
        push_byte(START_DELIM); push_byte(8'h00); push_byte(8'h01);
        push_byte(8'hFF); push_byte(8'h00);
        wait_drained();

        // directed: timeout while reading the length
        write_timeout(16'd2);
        push_byte(START_DELIM); push_byte(8'h00); push_tick(); push_tick();
        wait_drained();

        // directed: zero timeout fires on the first tick of a frame
        write_timeout(16'd0);
        push_byte(START_DELIM); push_byte(8'h00); push_byte(8'h03);
        push_byte(8'h11); push_tick();
        wait_drained();

        // random phases over timeouts and idle patterns
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_pressure(p % 4);
            write_timeout(phase_timeout[p]);
            add_random_traffic(RANDOM_ITEMS / RANDOM_PHASES);
            wait_drained();
        end

        // largest timeout: ticks inside a frame do not abandon it
        set_pressure(0);
        write_timeout(16'hFFFF);
        push_byte(START_DELIM); push_byte(8'h00); push_byte(8'h05); push_byte(8'hAB);
        repeat (20) push_tick();
        push_frame(1, 1'b1, 0);
        wait_drained();

        if (parser_events_due.size() != 0) begin
            $display("%0d expected results never arrived", parser_events_due.size());
            mismatches += parser_events_due.size();
        end
        $display("%0d requests driven, %0d results checked (%0d payload, %0d good, %0d bad, %0d timeout)",
                 accepted_count, checked_count, kind_seen[KIND_PAYLOAD], kind_seen[KIND_GOOD],
                 kind_seen[KIND_BAD], kind_seen[KIND_TIMEOUT]);
        $display("timeouts from 0 to 65535 under free flow, sender gaps, receiver stalls and both");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("run limit reached");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
